### hdl/stbf_pkg.sv
`default_nettype none

package stbf_pkg;

	// fixed field widths
	localparam int WIN_W  = 27;
	localparam int OVL_W  = 20;
	localparam int BYTE_W = 8;
	localparam int CFG_W  = 27;

	// default counter widths
	localparam int DEF_LINE_WIDTH = 32;
	localparam int DEF_SEQ_WIDTH  = 40;

	// register reset values
	localparam logic [WIN_W-1:0] WIN_LENGTH_RESET = WIN_W'(1000);
	localparam logic [OVL_W-1:0] OVERLAP_RESET    = '0;

	// input mode codes
	localparam logic MODE_TEXT  = 1'b0;
	localparam logic MODE_BEGIN = 1'b1;

	// character codes
	localparam logic [BYTE_W-1:0] CHAR_NL = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_GT = 8'h3E;
	localparam logic [BYTE_W-1:0] CHAR_N  = 8'h4E;
	localparam logic [BYTE_W-1:0] CHAR_UA = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_UC = 8'h43;
	localparam logic [BYTE_W-1:0] CHAR_UG = 8'h47;
	localparam logic [BYTE_W-1:0] CHAR_UT = 8'h54;
	localparam logic [BYTE_W-1:0] CHAR_LA = 8'h61;
	localparam logic [BYTE_W-1:0] CHAR_LC = 8'h63;
	localparam logic [BYTE_W-1:0] CHAR_LG = 8'h67;
	localparam logic [BYTE_W-1:0] CHAR_LT = 8'h74;

	typedef enum logic [0:0] {
		REG_WIN_LENGTH = 1'b0,
		REG_OVERLAP    = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		BASE_A = 2'd0,
		BASE_C = 2'd1,
		BASE_G = 2'd2,
		BASE_T = 2'd3
	} base_code_t;

	// classification of one text byte
	typedef struct packed {
		logic       newline;
		logic       header_open;
		logic       carriage;
		logic       symbol_n;
		logic       is_base;
		base_code_t code;
	} byte_class_t;

	// per-item result flags
	typedef struct packed {
		logic       base_valid;
		base_code_t base_code;
		logic       window_done;
	} result_flags_t;

endpackage

`default_nettype wire

### hdl/stbf_classify.sv
`default_nettype none

module stbf_classify (
	input  wire logic [stbf_pkg::BYTE_W-1:0] data_byte,
	output stbf_pkg::byte_class_t            cls
);
	import stbf_pkg::*;

	always_comb begin
		cls             = '0;
		cls.code        = BASE_A;
		cls.newline     = (data_byte == CHAR_NL);
		cls.header_open = (data_byte == CHAR_GT);
		cls.carriage    = (data_byte == CHAR_CR);
		cls.symbol_n    = (data_byte == CHAR_N);
		// lower-case acgt folds to upper case, lower-case n does not
		unique case (data_byte)
			CHAR_UA, CHAR_LA: begin
				cls.is_base = 1'b1;
				cls.code    = BASE_A;
			end
			CHAR_UC, CHAR_LC: begin
				cls.is_base = 1'b1;
				cls.code    = BASE_C;
			end
			CHAR_UG, CHAR_LG: begin
				cls.is_base = 1'b1;
				cls.code    = BASE_G;
			end
			CHAR_UT, CHAR_LT: begin
				cls.is_base = 1'b1;
				cls.code    = BASE_T;
			end
			default: begin
				cls.is_base = 1'b0;
				cls.code    = BASE_A;
			end
		endcase
	end

endmodule

`default_nettype wire

### hdl/stbf_state.sv
`default_nettype none

module stbf_state #(
	parameter int LINE_WIDTH = stbf_pkg::DEF_LINE_WIDTH,
	parameter int SEQ_WIDTH  = stbf_pkg::DEF_SEQ_WIDTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic                       mode,
	input  wire stbf_pkg::byte_class_t      cls,
	input  wire logic [stbf_pkg::WIN_W-1:0] win_length,
	input  wire logic [stbf_pkg::OVL_W-1:0] overlap,
	output stbf_pkg::result_flags_t         flags,
	output logic [stbf_pkg::WIN_W-1:0]      fill_next,
	output logic [LINE_WIDTH-1:0]           line_next,
	output logic [LINE_WIDTH-1:0]           col_next,
	output logic [SEQ_WIDTH-1:0]            sym_next
);
	import stbf_pkg::*;

	logic                  in_header_q;
	logic [LINE_WIDTH-1:0] line_q, col_q, saved_line_q, saved_col_q;
	logic [SEQ_WIDTH-1:0]  sym_q, saved_sym_q;
	logic [WIN_W-1:0]      fill_q;

	logic                  header_next;
	logic                  window_open;
	logic                  active;
	logic                  take_base;
	logic                  save_loc;
	logic [WIN_W-1:0]      fill_inc;
	logic [WIN_W-1:0]      save_point;
	logic [LINE_WIDTH-1:0] line_inc, col_inc;
	logic [SEQ_WIDTH-1:0]  sym_inc;

	// saturating increments
	assign line_inc = (&line_q) ? line_q : line_q + LINE_WIDTH'(1);
	assign col_inc  = (&col_q)  ? col_q  : col_q  + LINE_WIDTH'(1);
	assign sym_inc  = (&sym_q)  ? sym_q  : sym_q  + SEQ_WIDTH'(1);

	assign fill_inc    = fill_q + WIN_W'(1);
	assign save_point  = win_length - WIN_W'(overlap);
	assign window_open = (fill_q < win_length);

	always_comb begin
		header_next = in_header_q;
		if (cls.newline) begin
			header_next = 1'b0;
		end else if (cls.header_open) begin
			header_next = 1'b1;
		end
	end

	assign active    = (mode == MODE_TEXT) && window_open && !header_next;
	assign take_base = active && cls.is_base;
	assign save_loc  = take_base && (WIN_W'(overlap) < win_length) && (fill_inc == save_point);

	always_comb begin
		fill_next         = fill_q;
		line_next         = line_q;
		col_next          = col_q;
		sym_next          = sym_q;
		flags             = '0;
		flags.base_code   = BASE_A;
		if (mode == MODE_BEGIN) begin
			fill_next = '0;
			line_next = saved_line_q;
			col_next  = saved_col_q;
			sym_next  = saved_sym_q;
		end else if (window_open) begin
			if (cls.newline) begin
				line_next = line_inc;
				// the newline itself is the first column
				col_next  = LINE_WIDTH'(1);
			end else if (active && !cls.carriage) begin
				col_next = col_inc;
			end
			if (active && (cls.symbol_n || cls.is_base)) begin
				sym_next = sym_inc;
			end
			if (take_base) begin
				fill_next         = fill_inc;
				flags.base_valid  = 1'b1;
				flags.base_code   = cls.code;
				flags.window_done = (fill_inc == win_length);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q  <= 1'b0;
			line_q       <= '0;
			col_q        <= '0;
			sym_q        <= '0;
			fill_q       <= '0;
			saved_line_q <= '0;
			saved_col_q  <= '0;
			saved_sym_q  <= '0;
		end else if (step) begin
			line_q <= line_next;
			col_q  <= col_next;
			sym_q  <= sym_next;
			fill_q <= fill_next;
			if (mode == MODE_BEGIN) begin
				in_header_q <= 1'b0;
			end else if (window_open) begin
				in_header_q <= header_next;
			end
			if (save_loc) begin
				saved_line_q <= line_next;
				saved_col_q  <= col_next;
				saved_sym_q  <= sym_next;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/sequence_text_base_filter.sv
// channel   | handshake             | payload
// ----------+-----------------------+------------------------------------------------
// input     | in_valid / in_ready   | mode, data_byte
// result    | out_valid / out_ready | base flags, window count, line, column, position
// config    | cfg_we                | cfg_index, cfg_data (no wait, no read-back)
//
// one item per cycle sustained while out_ready is high: an item sits in the input
// register after acceptance and its result loads the result register once that slot
// is free or being emptied; the counter update is a single pass between the registers
// reset clears the valid flags, counters and saved location, window length 1000, overlap 0
// with out_ready low the result holds, one more item waits in the input register,
// then in_ready drops until out_ready returns
`default_nettype none

module sequence_text_base_filter #(
	parameter int LINE_WIDTH = stbf_pkg::DEF_LINE_WIDTH,
	parameter int SEQ_WIDTH  = stbf_pkg::DEF_SEQ_WIDTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        cfg_we,
	input  wire stbf_pkg::reg_index_t        cfg_index,
	input  wire logic [stbf_pkg::CFG_W-1:0]  cfg_data,
	// input items
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        mode,
	input  wire logic [stbf_pkg::BYTE_W-1:0] data_byte,
	// result items
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             base_valid,
	output logic [1:0]                       base_code,
	output logic                             window_done,
	output logic [stbf_pkg::WIN_W-1:0]       bases_in_window,
	output logic [LINE_WIDTH-1:0]            line_number,
	output logic [LINE_WIDTH-1:0]            line_column,
	output logic [SEQ_WIDTH-1:0]             seq_position
);
	import stbf_pkg::*;

	// configuration registers
	logic [WIN_W-1:0] win_length_q;
	logic [OVL_W-1:0] overlap_q;

	// input register
	logic              valid_s1;
	logic              mode_s1;
	logic [BYTE_W-1:0] byte_s1;

	// result register
	logic                  out_valid_q;
	result_flags_t         flags_q;
	logic [WIN_W-1:0]      fill_q;
	logic [LINE_WIDTH-1:0] line_q, col_q;
	logic [SEQ_WIDTH-1:0]  sym_q;

	byte_class_t           cls;
	result_flags_t         flags;
	logic [WIN_W-1:0]      fill_next;
	logic [LINE_WIDTH-1:0] line_next, col_next;
	logic [SEQ_WIDTH-1:0]  sym_next;
	logic                  advance;

	// the held item moves on when the result slot is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_length_q <= WIN_LENGTH_RESET;
			overlap_q    <= OVERLAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIN_LENGTH: win_length_q <= cfg_data[WIN_W-1:0];
				REG_OVERLAP:    overlap_q    <= cfg_data[OVL_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			byte_s1 <= data_byte;
		end
	end

	stbf_classify u_classify (
		.data_byte (byte_s1),
		.cls       (cls)
	);

	// position counters, window fill and saved location
	stbf_state #(
		.LINE_WIDTH (LINE_WIDTH),
		.SEQ_WIDTH  (SEQ_WIDTH)
	) u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.mode        (mode_s1),
		.cls         (cls),
		.win_length  (win_length_q),
		.overlap     (overlap_q),
		.flags       (flags),
		.fill_next   (fill_next),
		.line_next   (line_next),
		.col_next    (col_next),
		.sym_next    (sym_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (advance) begin
			flags_q <= flags;
			fill_q  <= fill_next;
			line_q  <= line_next;
			col_q   <= col_next;
			sym_q   <= sym_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign base_valid      = flags_q.base_valid;
	assign base_code       = flags_q.base_code;
	assign window_done     = flags_q.window_done;
	assign bases_in_window = fill_q;
	assign line_number     = line_q;
	assign line_column     = col_q;
	assign seq_position    = sym_q;

`ifndef SYNTH
	// a stalled result with a held item must block the input
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("input accepted while both stages are full");

	// a finished window comes only with a base
	a_done_needs_base: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && window_done |-> base_valid && (bases_in_window == win_length_q))
		else $error("window_done without a base or at the wrong count");

	// a base always leaves the window non-empty
	a_base_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && base_valid |-> bases_in_window != '0)
		else $error("base emitted with an empty window");

	// no base, no code
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !base_valid |-> base_code == BASE_A)
		else $error("base_code set without a base");
`endif

endmodule

`default_nettype wire
